// ----- src/fixed_slot_free_list_allocator_core_macros.svh -----
// assertion macros used by the allocator datapath
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// checked only while out of reset
`define FSLFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FSLFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fslfa_pkg.sv -----
// shared types and constants of the slot allocator
package fslfa_pkg;

    localparam int unsigned SLOTS_DEFAULT = 256;
    localparam int unsigned MAX_SLOTS     = 256;
    localparam int unsigned SLOT_W        = 8;
    localparam int unsigned STATUS_W      = 3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED    = 3'd0,
        ST_FRESH     = 3'd1,
        ST_FREED     = 3'd2,
        ST_NULL      = 3'd3,
        ST_EXHAUSTED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_FRESH,
        OP_POP_READ,
        OP_POP_DONE,
        OP_REJECT_NULL,
        OP_REJECT_EXH
    } t_dp_op;

    typedef struct packed {
        logic is_free;
        logic slot_ok;
        logic head_empty;
        logic fresh_avail;
    } t_dp_stat;

endpackage

// ----- src/fslfa_ram.sv -----
// generic simple dual port ram with registered read
module fslfa_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/fslfa_ctrl.sv -----
// controller state machine of the slot allocator
module fslfa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  fslfa_pkg::t_dp_stat i_stat,
    output fslfa_pkg::t_dp_op   o_op,
    output logic                o_busy
);

    import fslfa_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_POP
    } t_state;

    t_state r_state;
    logic   r_busy;
    t_dp_op n_op;

    always_comb begin
        n_op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_stat.is_free) begin
                        n_op = i_stat.slot_ok ? OP_PUSH : OP_REJECT_NULL;
                    end else if (!i_stat.head_empty) begin
                        n_op = OP_POP_READ;
                    end else if (i_stat.fresh_avail) begin
                        n_op = OP_FRESH;
                    end else begin
                        n_op = OP_REJECT_EXH;
                    end
                end
            end
            S_POP: begin
                n_op = OP_POP_DONE;
            end
            default: begin
                n_op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (n_op == OP_POP_READ) begin
                        r_state <= S_POP;
                        r_busy  <= 1'b1;
                    end
                end
                S_POP: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_op   = n_op;
    assign o_busy = r_busy;

endmodule

// ----- src/fslfa_dp.sv -----
// datapath of the slot allocator: list head, bump counter, link store, result beat
module fslfa_dp #(
    parameter int unsigned SLOTS = fslfa_pkg::SLOTS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_func,
    input  logic [fslfa_pkg::SLOT_W-1:0]      i_slot_index,
    input  logic                              i_is_null,
    input  fslfa_pkg::t_dp_op                 i_op,
    output fslfa_pkg::t_dp_stat               o_stat,
    output logic                              o_done,
    output logic [fslfa_pkg::SLOT_W-1:0]      o_granted_slot,
    output logic [fslfa_pkg::STATUS_W-1:0]    o_status
);

    import fslfa_pkg::*;

    `include "fixed_slot_free_list_allocator_core_macros.svh"

    localparam int unsigned USABLE = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
    localparam int unsigned AW     = $clog2(USABLE);
    localparam int unsigned LW     = AW + 1;
    localparam int unsigned CNT_W  = $clog2(USABLE + 1);
    localparam logic [LW-1:0] HEAD_EMPTY = {1'b1, {AW{1'b0}}};

    logic [LW-1:0]     r_head;
    logic [CNT_W-1:0]  r_fresh;
    logic              r_done;
    logic [SLOT_W-1:0] r_granted;
    t_status           r_status;

    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [LW-1:0]     ram_wdata;
    logic [LW-1:0]     ram_rdata;

    always_comb begin
        o_stat.is_free     = (i_func == FUNC_FREE);
        o_stat.slot_ok     = !i_is_null
                             && ({1'b0, i_slot_index} < (SLOT_W + 1)'(USABLE));
        o_stat.head_empty  = r_head[AW];
        o_stat.fresh_avail = (r_fresh < CNT_W'(USABLE));
    end

    assign ram_we    = (i_op == OP_PUSH);
    assign ram_waddr = i_slot_index[AW-1:0];
    assign ram_wdata = r_head;
    assign ram_re    = (i_op == OP_POP_READ);
    assign ram_raddr = r_head[AW-1:0];

    fslfa_ram #(
        .WIDTH (LW),
        .DEPTH (USABLE),
        .AW    (AW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= HEAD_EMPTY;
            r_fresh <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (i_op)
                OP_PUSH: begin
                    r_head <= {1'b0, i_slot_index[AW-1:0]};
                    r_done <= 1'b1;
                end
                OP_FRESH: begin
                    r_fresh <= r_fresh + CNT_W'(1);
                    r_done  <= 1'b1;
                end
                OP_POP_DONE: begin
                    r_head <= ram_rdata;
                    r_done <= 1'b1;
                end
                OP_REJECT_NULL, OP_REJECT_EXH: begin
                    r_done <= 1'b1;
                end
                default: begin
                    r_done <= 1'b0;
                end
            endcase
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_PUSH: begin
                r_granted <= '0;
                r_status  <= ST_FREED;
            end
            OP_FRESH: begin
                r_granted <= SLOT_W'(r_fresh);
                r_status  <= ST_FRESH;
            end
            OP_POP_DONE: begin
                r_granted <= SLOT_W'(r_head[AW-1:0]);
                r_status  <= ST_REUSED;
            end
            OP_REJECT_NULL: begin
                r_granted <= '0;
                r_status  <= ST_NULL;
            end
            OP_REJECT_EXH: begin
                r_granted <= '0;
                r_status  <= ST_EXHAUSTED;
            end
            default: begin
                r_granted <= r_granted;
                r_status  <= r_status;
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_granted_slot = r_granted;
    assign o_status       = r_status;

    `FSLFA_ASSERT(a_pop_read_no_beat, i_clk, i_rst_n,
        (i_op == OP_POP_READ) |=> !r_done, "beat issued before link read returned")
    `FSLFA_ASSERT(a_pop_done_reused, i_clk, i_rst_n,
        (i_op == OP_POP_DONE) |=> (r_done && r_status == ST_REUSED), "pop beat missing")
    `FSLFA_ASSERT(a_fresh_bound, i_clk, i_rst_n,
        $past(i_rst_n) |-> (r_fresh <= CNT_W'(USABLE)), "bump counter past pool size")
    `FSLFA_ASSERT(a_zero_grant, i_clk, i_rst_n,
        (r_done && r_status != ST_REUSED && r_status != ST_FRESH) |-> (r_granted == '0),
        "nonzero slot on a beat without a grant")
    `FSLFA_ASSERT_ALWAYS(a_no_beat_after_reset, i_clk,
        $past(!i_rst_n) |-> !r_done, "beat right after reset")

endmodule

// ----- src/fixed_slot_free_list_allocator_core.sv -----
// Fixed-size slot pool allocator with a LIFO free list and a bump counter for unused slots.
// A request is taken when start is high and busy is low. Free, null free, fresh allocate
// and exhausted allocate never raise busy and can follow one another every cycle; an
// allocate that pops the free list first issues the registered read of the link memory
// and then holds busy high in the S_POP state, where the read link becomes the new head.
// Each request gives exactly one result beat, o_done high for one cycle: in the cycle after
// the request for the other kinds, and after the S_POP state for a pop. The receiver cannot
// stall: a beat not captured in its cycle is gone. The link memory is not cleared after reset,
// so the block is ready at once.
module fixed_slot_free_list_allocator_core #(
    parameter int unsigned SLOTS = fslfa_pkg::SLOTS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [fslfa_pkg::SLOT_W-1:0]      i_slot_index,
    input  logic                              i_is_null,
    output logic                              o_done,
    output logic [fslfa_pkg::SLOT_W-1:0]      o_granted_slot,
    output logic [fslfa_pkg::STATUS_W-1:0]    o_status
);

    import fslfa_pkg::*;

    t_dp_op   op;
    t_dp_stat stat;

    fslfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy)
    );

    fslfa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_func),
        .i_slot_index   (i_slot_index),
        .i_is_null      (i_is_null),
        .i_op           (op),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_granted_slot (o_granted_slot),
        .o_status       (o_status)
    );

endmodule

// ----- test/testbench.sv -----
// self-checking bench for the slot pool allocator: predicts every grant and compares each beat
import fslfa_pkg::*;

typedef struct packed {
    logic [SLOT_W-1:0] slot;
    t_status           status;
} t_grant;

class pool_tracker;
    int unsigned pool_size;
    logic [8:0]  bump_ptr;
    logic [8:0]  list_top;
    logic [8:0]  link_mem [MAX_SLOTS];
    t_grant      expected_grants [$];
    int          errors;
    int          status_count [5];

    function new(int unsigned slots);
        pool_size = (slots < MAX_SLOTS) ? slots : MAX_SLOTS;
        bump_ptr  = '0;
        list_top  = 9'(MAX_SLOTS);
        errors    = 0;
        foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function t_grant note_request(logic func, logic [SLOT_W-1:0] slot, logic nul);
        t_grant g;
        g.slot = '0;
        if (func == FUNC_ALLOC) begin
            if (list_top < MAX_SLOTS) begin
                g.slot   = list_top[SLOT_W-1:0];
                list_top = link_mem[list_top[SLOT_W-1:0]];
                g.status = ST_REUSED;
            end else if (bump_ptr < pool_size) begin
                g.slot   = bump_ptr[SLOT_W-1:0];
                bump_ptr = bump_ptr + 9'd1;
                g.status = ST_FRESH;
            end else begin
                g.status = ST_EXHAUSTED;
            end
        end else if (nul || slot >= pool_size) begin
            g.status = ST_NULL;
        end else begin
            link_mem[slot] = list_top;
            list_top       = {1'b0, slot};
            g.status       = ST_FREED;
        end
        status_count[g.status]++;
        expected_grants.push_back(g);
        return g;
    endfunction

    function void check_result(logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] status);
        t_grant g;
        if (expected_grants.size() == 0) begin
            $display("%0t: result beat with nothing pending, slot %0d status %0d",
                     $time, slot, status);
            errors++;
            return;
        end
        g = expected_grants.pop_front();
        if (slot !== g.slot) begin
            $display("%0t: granted_slot expected %0d got %0d", $time, g.slot, slot);
            errors++;
        end
        if (status !== g.status) begin
            $display("%0t: status expected %0d got %0d", $time, g.status, status);
            errors++;
        end
    endfunction

    function int outstanding();
        return expected_grants.size();
    endfunction
endclass

module testbench;
    localparam int unsigned POOL = SLOTS_DEFAULT;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_func;
    logic [SLOT_W-1:0]   i_slot_index;
    logic                i_is_null;
    logic                o_done;
    logic [SLOT_W-1:0]   o_granted_slot;
    logic [STATUS_W-1:0] o_status;

    pool_tracker tracker;
    int          held_slots [$];
    bit          in_use [MAX_SLOTS];
    int          burst_left;
    int          items_sent;

    fixed_slot_free_list_allocator_core #(.SLOTS(POOL)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_slot_index   (i_slot_index),
        .i_is_null      (i_is_null),
        .o_done         (o_done),
        .o_granted_slot (o_granted_slot),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_result(o_granted_slot, o_status);
    end

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start        = 1'b0;
            i_func       = 1'($urandom);
            i_slot_index = 8'($urandom);
            i_is_null    = 1'($urandom);
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic issue(logic func, logic [SLOT_W-1:0] slot, logic nul);
        t_grant g;
        start        = 1'b1;
        i_func       = func;
        i_slot_index = slot;
        i_is_null    = nul;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        g = tracker.note_request(func, slot, nul);
        if (func == FUNC_ALLOC && (g.status == ST_REUSED || g.status == ST_FRESH)
                && !in_use[g.slot]) begin
            held_slots.push_back(g.slot);
            in_use[g.slot] = 1'b1;
        end
        items_sent++;
        @(negedge i_clk);
        pace();
    endtask

    task automatic release_slot(int s);
        int idx;
        idx = -1;
        foreach (held_slots[i]) if (held_slots[i] == s) idx = i;
        if (idx >= 0) held_slots.delete(idx);
        in_use[s] = 1'b0;
        issue(FUNC_FREE, 8'(s), 1'b0);
    endtask

    task automatic drain();
        start = 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic random_item(int alloc_pct, bit allow_broken);
        int r;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            issue(FUNC_ALLOC, 8'($urandom), 1'($urandom));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 10)
                issue(FUNC_FREE, 8'($urandom), 1'b1);
            else if (allow_broken && r < 22)
                issue(FUNC_FREE, 8'($urandom), 1'b0);
            else if (held_slots.size() != 0)
                release_slot(held_slots[$urandom_range(0, held_slots.size() - 1)]);
            else
                issue(FUNC_ALLOC, 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int s;
        tracker      = new(POOL);
        items_sent   = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_func       = FUNC_ALLOC;
        i_slot_index = '0;
        i_is_null    = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed beats, back to back
        burst_left = 100;
        issue(FUNC_ALLOC, 8'd0, 1'b0);
        issue(FUNC_ALLOC, 8'd255, 1'b1);
        issue(FUNC_ALLOC, 8'd0, 1'b0);
        release_slot(1);
        release_slot(0);
        issue(FUNC_ALLOC, 8'd0, 1'b0);
        issue(FUNC_ALLOC, 8'd255, 1'b0);
        issue(FUNC_ALLOC, 8'd0, 1'b1);
        issue(FUNC_FREE, 8'd255, 1'b1);
        issue(FUNC_FREE, 8'd0, 1'b1);
        // slot never handed out, then taken straight back and retired
        issue(FUNC_FREE, 8'd255, 1'b0);
        issue(FUNC_ALLOC, 8'd0, 1'b0);
        void'(held_slots.pop_back());
        release_slot(3);
        issue(FUNC_ALLOC, 8'd170, 1'b1);
        release_slot(2);
        release_slot(0);
        issue(FUNC_ALLOC, 8'd85, 1'b0);
        issue(FUNC_ALLOC, 8'd0, 1'b0);
        issue(FUNC_ALLOC, 8'd0, 1'b0);
        release_slot(1);
        issue(FUNC_ALLOC, 8'd0, 1'b0);
        drain();

        burst_left = 0;
        repeat (80) random_item(55, 1'b0);
        drain();

        // fill the pool until it runs dry several times
        for (int n = 0; n < 400 && tracker.status_count[ST_EXHAUSTED] < 8; n++)
            random_item(98, 1'b0);
        drain();

        // double free, then noisy traffic
        if (held_slots.size() != 0) begin
            s = held_slots[0];
            release_slot(s);
            issue(FUNC_FREE, 8'(s), 1'b0);
            issue(FUNC_ALLOC, 8'($urandom), 1'b0);
            issue(FUNC_ALLOC, 8'($urandom), 1'b0);
        end
        repeat (100) random_item(45, 1'b1);
        drain();
        repeat (6) @(negedge i_clk);

        $display("ran %0d requests: %0d reused, %0d fresh, %0d freed, %0d null, %0d exhausted",
                 items_sent, tracker.status_count[ST_REUSED], tracker.status_count[ST_FRESH],
                 tracker.status_count[ST_FREED], tracker.status_count[ST_NULL],
                 tracker.status_count[ST_EXHAUSTED]);
        $display("%0d mismatches found", tracker.errors);
        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/fslfa_pkg.sv
src/fslfa_ram.sv
src/fslfa_ctrl.sv
src/fslfa_dp.sv
src/fixed_slot_free_list_allocator_core.sv
test/testbench.sv
